### hdl/mipssc_pkg.sv
// Shared definitions for the MIPS subset core: ISA codes, item codes and
// the control structs passed between the core and its memories. No dependencies.
package mipssc_pkg;

  // Primary opcodes, instruction[31:26]. The all-ones word decodes as halt.
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_HALT  = 6'h3F;

  // ALU select, funct[2:0] of R-type words
  localparam logic [2:0] ALU_ADDU = 3'd1;
  localparam logic [2:0] ALU_SUBU = 3'd3;
  localparam logic [2:0] ALU_AND  = 3'd4;
  localparam logic [2:0] ALU_OR   = 3'd5;
  localparam logic [2:0] ALU_NOR  = 3'd7;

  // Item kind on the input channel
  localparam logic ITEM_EXEC    = 1'b0;
  localparam logic ITEM_PRELOAD = 1'b1;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic write;
    logic read;
  } dmem_ctl_t;

endpackage

### hdl/mips_subset_single_cycle_core_unit.sv
// MIPS subset core: decode/execute stage after a registered register-file read,
// then a memory sequencer for lw, sw and preload on a byte-wide data memory.
// lw (4 byte accesses), sw and preload pass through the sequencer. Throughput:
// 1 item/cycle for non-memory items unless out_stall holds the result; a memory
// item holds the execute stage until its byte sequence ends. Reset: PC and
// registers zero at once, then a zero-fill of the data memory with in_stall high.
module mips_subset_single_cycle_core_unit #(
  parameter int DATA_MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] instruction,
  input  logic [15:0] preload_address,
  input  logic [7:0]  preload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic        halted,
  output logic        reg_write,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic        mem_write,
  output logic        mem_read,
  output logic [15:0] mem_address,
  output logic [31:0] mem_value
);
  import mipssc_pkg::*;

  localparam int ADDR_W = $clog2(DATA_MEM_BYTES);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DATA_MEM_BYTES - 1);

  localparam logic [2:0] S2_IDLE  = 3'd0;
  localparam logic [2:0] S2_ADDR  = 3'd1;
  localparam logic [2:0] S2_WRAP  = 3'd2;
  localparam logic [2:0] S2_STORE = 3'd3;
  localparam logic [2:0] S2_LOAD  = 3'd4;
  localparam logic [2:0] S2_TAIL  = 3'd5;
  localparam logic [2:0] S2_FIN   = 3'd6;

  localparam logic [1:0] JOB_LOAD    = 2'd0;
  localparam logic [1:0] JOB_STORE   = 2'd1;
  localparam logic [1:0] JOB_PRELOAD = 2'd2;

  logic        accept, clearing;
  logic [31:0] pc;

  // execute stage
  logic        s1_valid, s1_item;
  logic [31:0] s1_insn;
  logic [15:0] s1_paddr;
  logic [7:0]  s1_pbyte;
  logic        fwd_a_hit, fwd_b_hit;
  logic [31:0] fwd_a_data, fwd_b_data;
  logic [31:0] rf_qa, rf_qb;
  rf_wr_t      rf_wr;
  logic [5:0]  s1_op;
  logic [4:0]  s1_rs, s1_rt, s1_rd;
  logic [31:0] op_a, op_b, simm, pc4, alu_res, sum_ai;
  logic        s1_to_s2, s1_adv, slot_free, s2_idle, s1_direct;
  logic [31:0] x_pc_next, x_wb_val;
  logic        x_halt, x_wb;
  logic [4:0]  x_wb_idx;

  // memory sequencer
  logic [2:0]        s2_state;
  logic [1:0]        job_kind, s2_cnt, job_last;
  logic [31:0]       job_x, job_pc, job_b, sdata, word;
  logic [4:0]        job_rt;
  logic [ADDR_W-1:0] base, baddr, baddr_inc;
  logic              rd_pend, s2_push, s2_start;
  logic              wrap_in_valid, wrap_out_valid;
  logic [ADDR_W-1:0] wrap_r;
  dmem_ctl_t         dm_ctl;
  logic [7:0]        dm_rdata;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = clearing || (s1_valid && !s1_adv);
  assign slot_free = !out_valid || !out_stall;
  assign s2_idle   = (s2_state == S2_IDLE);
  assign s1_adv    = s1_valid && s2_idle && (s1_to_s2 || slot_free);
  assign s1_direct = s1_adv && !s1_to_s2;
  assign s2_start  = s1_adv && s1_to_s2;
  assign s2_push   = (s2_state == S2_FIN) && slot_free;

  mipssc_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .re      (accept),
    .raddr_a (instruction[25:21]),
    .raddr_b (instruction[20:16]),
    .rdata_a (rf_qa),
    .rdata_b (rf_qb),
    .wr      (rf_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= opcode;
      s1_insn  <= instruction;
      s1_paddr <= preload_address;
      s1_pbyte <= preload_byte;
    end
  end

  // Operand bypass: catch any register write at or after the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a_hit <= 1'b0;
      fwd_b_hit <= 1'b0;
    end else if (accept) begin
      fwd_a_hit  <= rf_wr.en && (rf_wr.addr == instruction[25:21]);
      fwd_b_hit  <= rf_wr.en && (rf_wr.addr == instruction[20:16]);
      fwd_a_data <= rf_wr.data;
      fwd_b_data <= rf_wr.data;
    end else begin
      if (rf_wr.en && (rf_wr.addr == s1_rs)) begin
        fwd_a_hit  <= 1'b1;
        fwd_a_data <= rf_wr.data;
      end
      if (rf_wr.en && (rf_wr.addr == s1_rt)) begin
        fwd_b_hit  <= 1'b1;
        fwd_b_data <= rf_wr.data;
      end
    end
  end

  assign s1_op  = s1_insn[31:26];
  assign s1_rs  = s1_insn[25:21];
  assign s1_rt  = s1_insn[20:16];
  assign s1_rd  = s1_insn[15:11];
  assign op_a   = fwd_a_hit ? fwd_a_data : rf_qa;
  assign op_b   = fwd_b_hit ? fwd_b_data : rf_qb;
  assign simm   = {{16{s1_insn[15]}}, s1_insn[15:0]};
  assign pc4    = pc + 32'd4;
  assign sum_ai = op_a + simm;

  always_comb begin
    case (s1_insn[2:0])
      ALU_ADDU: alu_res = op_a + op_b;
      ALU_SUBU: alu_res = op_a - op_b;
      ALU_AND:  alu_res = op_a & op_b;
      ALU_OR:   alu_res = op_a | op_b;
      ALU_NOR:  alu_res = ~(op_a | op_b);
      default:  alu_res = '0;
    endcase
  end

  always_comb begin
    x_pc_next = pc4;
    x_halt    = 1'b0;
    x_wb      = 1'b0;
    x_wb_idx  = s1_rd;
    x_wb_val  = alu_res;
    s1_to_s2  = 1'b0;
    if (s1_item == ITEM_PRELOAD) begin
      x_pc_next = pc;
      s1_to_s2  = 1'b1;
    end else begin
      case (s1_op)
        OP_HALT: begin
          x_pc_next = pc;
          x_halt    = 1'b1;
        end
        OP_RTYPE: x_wb = 1'b1;
        OP_J:     x_pc_next = {pc4[31:28], s1_insn[25:0], 2'b00};
        OP_BEQ: begin
          if (op_a == op_b) begin
            x_pc_next = pc4 + {simm[29:0], 2'b00};
          end
        end
        OP_ADDIU: begin
          x_wb     = 1'b1;
          x_wb_idx = s1_rt;
          x_wb_val = sum_ai;
        end
        OP_LW, OP_SW: s1_to_s2 = 1'b1;
        default: ;
      endcase
    end
  end

  // register 0 is never written, so its valid bit keeps it reading zero
  always_comb begin
    rf_wr.en   = 1'b0;
    rf_wr.addr = x_wb_idx;
    rf_wr.data = x_wb_val;
    if (s1_direct && x_wb && (x_wb_idx != 5'd0)) begin
      rf_wr.en = 1'b1;
    end else if (s2_push && (job_kind == JOB_LOAD) && (job_rt != 5'd0)) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = job_rt;
      rf_wr.data = word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_adv && (s1_item == ITEM_EXEC)) begin
      pc <= x_pc_next;
    end
  end

  // ---- memory sequencer ----
  assign wrap_in_valid = (s2_state == S2_ADDR);
  assign dm_ctl.write  = (s2_state == S2_STORE);
  assign dm_ctl.read   = (s2_state == S2_LOAD);
  assign baddr_inc     = (baddr == ADDR_LAST) ? '0 : baddr + ADDR_W'(1);

  mipssc_wrap #(.DATA_MEM_BYTES(DATA_MEM_BYTES)) u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wrap_in_valid),
    .x         (job_x),
    .out_valid (wrap_out_valid),
    .r         (wrap_r)
  );

  mipssc_dmem #(.DATA_MEM_BYTES(DATA_MEM_BYTES)) u_dmem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dm_ctl),
    .addr     (baddr),
    .wdata    (sdata[31:24]),
    .rdata    (dm_rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_state <= S2_IDLE;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= dm_ctl.read;
      case (s2_state)
        S2_IDLE: begin
          if (s2_start) begin
            s2_state <= S2_ADDR;
          end
        end
        S2_ADDR: s2_state <= S2_WRAP;
        S2_WRAP: begin
          if (wrap_out_valid) begin
            s2_state <= (job_kind == JOB_LOAD) ? S2_LOAD : S2_STORE;
          end
        end
        S2_STORE: begin
          if (s2_cnt == job_last) begin
            s2_state <= S2_FIN;
          end
        end
        S2_LOAD: begin
          if (s2_cnt == 2'd3) begin
            s2_state <= S2_TAIL;
          end
        end
        S2_TAIL: s2_state <= S2_FIN;
        S2_FIN: begin
          if (slot_free) begin
            s2_state <= S2_IDLE;
          end
        end
        default: s2_state <= S2_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s2_start) begin
      job_pc <= x_pc_next;
      job_b  <= op_b;
      job_rt <= s1_rt;
      s2_cnt <= 2'd0;
      if (s1_item == ITEM_PRELOAD) begin
        job_kind <= JOB_PRELOAD;
        job_x    <= 32'(s1_paddr);
        sdata    <= {s1_pbyte, 24'd0};
        job_last <= 2'd0;
      end else begin
        job_kind <= (s1_op == OP_LW) ? JOB_LOAD : JOB_STORE;
        job_x    <= sum_ai;
        sdata    <= op_b;
        job_last <= 2'd3;
      end
    end else if (dm_ctl.write || dm_ctl.read) begin
      s2_cnt <= s2_cnt + 2'd1;
      sdata  <= {sdata[23:0], 8'd0};
    end
    if ((s2_state == S2_WRAP) && wrap_out_valid) begin
      base  <= wrap_r;
      baddr <= wrap_r;
    end else if (dm_ctl.write || dm_ctl.read) begin
      baddr <= baddr_inc;
    end
    // big-endian: first byte lands in the top of the word
    if (rd_pend) begin
      word <= {word[23:0], dm_rdata};
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_direct || s2_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_direct) begin
      next_pc     <= x_pc_next;
      halted      <= x_halt;
      reg_write   <= rf_wr.en;
      reg_index   <= rf_wr.en ? x_wb_idx : 5'd0;
      reg_value   <= rf_wr.en ? x_wb_val : 32'd0;
      mem_write   <= 1'b0;
      mem_read    <= 1'b0;
      mem_address <= 16'd0;
      mem_value   <= 32'd0;
    end else if (s2_push) begin
      next_pc     <= job_pc;
      halted      <= 1'b0;
      reg_write   <= rf_wr.en;
      reg_index   <= rf_wr.en ? job_rt : 5'd0;
      reg_value   <= rf_wr.en ? word : 32'd0;
      mem_write   <= (job_kind == JOB_STORE);
      mem_read    <= (job_kind == JOB_LOAD);
      mem_address <= (job_kind == JOB_PRELOAD) ? 16'd0 : 16'(base);
      case (job_kind)
        JOB_STORE: mem_value <= job_b;
        JOB_LOAD:  mem_value <= word;
        default:   mem_value <= 32'd0;
      endcase
    end
  end

endmodule

### hdl/mipssc_regfile.sv
// 32 x 32 register file: two registered read ports, one write port.
// Per-entry valid bits make the whole file read as zero after reset. Uses mipssc_pkg.
module mipssc_regfile (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [4:0]          raddr_a,
  input  logic [4:0]          raddr_b,
  output logic [31:0]         rdata_a,
  output logic [31:0]         rdata_b,
  input  mipssc_pkg::rf_wr_t  wr
);
  import mipssc_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-first: a write at the same edge is not seen here
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= valid[raddr_a] ? mem[raddr_a] : '0;
      rdata_b <= valid[raddr_b] ? mem[raddr_b] : '0;
    end
  end

endmodule

### hdl/mipssc_dmem.sv
// Byte-wide data memory with one registered read or write per cycle and a
// zero-fill sweep after reset. Uses mipssc_pkg.
module mipssc_dmem #(
  parameter int DATA_MEM_BYTES = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mipssc_pkg::dmem_ctl_t            ctl,
  input  logic [$clog2(DATA_MEM_BYTES)-1:0] addr,
  input  logic [7:0]                       wdata,
  output logic [7:0]                       rdata,
  output logic                             clearing
);
  import mipssc_pkg::*;

  localparam int ADDR_W = $clog2(DATA_MEM_BYTES);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DATA_MEM_BYTES - 1);

  logic [7:0]        mem [DATA_MEM_BYTES];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (ctl.write) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/mipssc_wrap.sv
// Three-stage reduction of a 32-bit byte address modulo the memory size:
// reciprocal multiply, back-multiply, one correcting subtract. No dependencies.
module mipssc_wrap #(
  parameter int DATA_MEM_BYTES = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [31:0]                       x,
  output logic                              out_valid,
  output logic [$clog2(DATA_MEM_BYTES)-1:0] r
);
  localparam int ADDR_W  = $clog2(DATA_MEM_BYTES);
  localparam int RECIP_W = 34 - ADDR_W;
  localparam int PROD_W  = 32 + RECIP_W;
  localparam int QN_W    = RECIP_W + ADDR_W + 1;
  localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(DATA_MEM_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [ADDR_W:0] MODV = (ADDR_W + 1)'(DATA_MEM_BYTES);

  logic [1:0]         vld;
  logic [PROD_W-1:0]  xm, prod1;
  logic [31:0]        x1, x2, prod2;
  logic [RECIP_W-1:0] q;
  logic [QN_W-1:0]    qn;
  logic [31:0]        diff;
  logic [ADDR_W:0]    dlow;

  assign xm   = PROD_W'(x) * PROD_W'(RECIP);
  assign q    = prod1[PROD_W-1:32];
  assign qn   = QN_W'(q) * QN_W'(MODV);
  // quotient estimate is low by at most one, so the remainder is below 2N
  assign diff = x2 - prod2;
  assign dlow = diff[ADDR_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= xm;
    x1    <= x;
    prod2 <= qn[31:0];
    x2    <= x1;
    r     <= (dlow >= MODV) ? ADDR_W'(dlow - MODV) : dlow[ADDR_W-1:0];
  end

endmodule

### hdl/mipssc_checker.sv
// Port-level checks for the MIPS subset core, attached by bind to the top level.
// Sees only the top-level ports; no package dependency.
module mipssc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] next_pc,
  input logic        halted,
  input logic        reg_write,
  input logic [4:0]  reg_index,
  input logic [31:0] reg_value,
  input logic        mem_write,
  input logic        mem_read,
  input logic [31:0] mem_value
);

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(reg_value)
      && $stable(mem_value))
    else $error("result changed while stalled");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !reg_write && !mem_write && !mem_read)
    else $error("halt result carries side effects");

  a_load_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_read && reg_write |-> (reg_value == mem_value) && !mem_write)
    else $error("load write-back differs from loaded word");

  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write |-> reg_index != 5'd0)
    else $error("write to register zero reported");

  // memory zero-fill holds off input after reset
  a_reset_fill: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted right after reset");

endmodule

bind mips_subset_single_cycle_core_unit mipssc_checker u_chk (.*);
